// ===== rtl/core/cda_pkg.sv =====
// Shared types, constants and date helper functions for the calendar date unit.
// No dependencies; used by every module of the block.
`default_nettype none

package cda_pkg;

    // Operation codes
    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_DAYS   = 2'd1;
    localparam logic [1:0] OP_MONTHS = 2'd2;
    localparam logic [1:0] OP_YEARS  = 2'd3;

    // Date range and reset values
    localparam logic [13:0] YEAR_MAX        = 14'd9999;
    localparam logic [13:0] LEAP_START_RST  = 14'd1753;
    localparam logic [13:0] YEAR_RST        = 14'd2000;
    localparam logic [3:0]  MONTH_RST       = 4'd1;
    localparam logic [4:0]  DAY_RST         = 5'd1;
    localparam logic [16:0] MONTH_IDX_MAX   = 17'd119999;  // 9999*12 + 11

    // Divisibility by 25: y*inv(25) mod 2^14 <= floor((2^14-1)/25)
    localparam logic [13:0] INV25           = 14'd7209;
    localparam logic [13:0] DIV25_MAX       = 14'd655;

    // Division by 12 as a reciprocal multiply: q = (idx * RECIP12) >> RECIP12_SHIFT
    localparam logic [17:0] RECIP12         = 18'd174763;
    localparam int          RECIP12_SHIFT   = 21;

    // Command word
    typedef struct packed {
        logic [1:0]         op;
        logic [13:0]        year_value;
        logic [3:0]         month_value;
        logic [5:0]         day_value;
        logic signed [15:0] amount;
    } cda_cmd_word_t;

    // Result word
    typedef struct packed {
        logic [13:0] year_now;
        logic [3:0]  month_now;
        logic [4:0]  day_now;
        logic [4:0]  month_length;
        logic        is_leap;
        logic [26:0] date_stamp;
        logic        year_clamped;
    } cda_res_word_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic exec;
        logic mdiv;
        logic mrem;
        logic dstep;
        logic clamp;
        logic load_res;
    } cda_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       step_done;
    } cda_sts_t;

    // Gregorian leap rule, never leap below the start year
    function automatic logic leap_of(input logic [13:0] y, input logic [13:0] start);
        logic [27:0] prod;
        logic        div25;
        logic        leap;
        prod  = 28'(y) * 28'(INV25);
        div25 = (prod[13:0] <= DIV25_MAX);
        if (y < start)
            leap = 1'b0;
        else if (y[1:0] != 2'b00)
            leap = 1'b0;
        else if (!div25)
            leap = 1'b1;               // multiple of 4, not of 100
        else
            leap = (y[3:0] == 4'd0);   // century: leap only if multiple of 400
        return leap;
    endfunction

    // Days in a month
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/calendar_date_arithmetic_unit.sv =====
// Top level of the calendar date unit: controller plus datapath.
// Depends on cda_pkg, cda_ctrl and cda_dp.
`default_nettype none

// Holds one calendar date and applies one operation per command word:
// set date, add days, add months or add years (cmd_word.op).
// Command and result channels use valid/ready; a word moves when both are high.
// Every command word yields exactly one result word: the date after the
// operation, month length, leap flag, packed stamp and a saturation flag.
// cfg_we/cfg_data write the leap start year; write only while idle.
// States from acceptance to res_valid:
//   set date, add years : EXEC, CLAMP, DONE
//   add months          : EXEC, MDIV (quotient), MREM (remainder), CLAMP, DONE
//   add days            : EXEC, DSTEP until the days fit, then DONE; one step
//                         per month boundary, about 1080 for the largest amount
// The day stepper advances one month per cycle.
// One command is in flight at a time; cmd_ready returns the cycle after the
// result is loaded into the output register, so a new command can be taken
// while that result still waits for res_ready.
// When the receiver stalls the finished result holds the output register and
// the next command stalls before its own result is loaded.
// Reset: date 2000-01-01, leap start year 1753, no result pending.

module calendar_date_arithmetic_unit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [13:0]            cfg_data,
    input  wire logic                   cmd_valid,
    output logic                        cmd_ready,
    input  wire cda_pkg::cda_cmd_word_t cmd_word,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output cda_pkg::cda_res_word_t      res_word
);

    cda_pkg::cda_ctl_t ctl;
    cda_pkg::cda_sts_t sts;

    cda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    cda_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd_word (cmd_word),
        .ctl      (ctl),
        .sts      (sts),
        .res_word (res_word)
    );

endmodule

`default_nettype wire

// ===== rtl/core/cda_ctrl.sv =====
// Sequencing state machine for the calendar date unit.
// Depends on cda_pkg; drives cda_dp through command and status structs.
`default_nettype none

module cda_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    output logic                   res_valid,
    input  wire logic              res_ready,
    input  wire cda_pkg::cda_sts_t sts,
    output cda_pkg::cda_ctl_t      ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_MDIV  = 3'd2;
    localparam logic [2:0] S_MREM  = 3'd3;
    localparam logic [2:0] S_DSTEP = 3'd4;
    localparam logic [2:0] S_CLAMP = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       res_valid_reg;
    logic       res_valid_next;

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        ctl            = '0;
        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
                case (sts.op)
                    cda_pkg::OP_DAYS:   state_next = S_DSTEP;
                    cda_pkg::OP_MONTHS: state_next = S_MDIV;
                    default:            state_next = S_CLAMP;
                endcase
            end
            S_MDIV:
            begin
                ctl.mdiv   = 1'b1;
                state_next = S_MREM;
            end
            S_MREM:
            begin
                ctl.mrem   = 1'b1;
                state_next = S_CLAMP;
            end
            S_DSTEP:
            begin
                ctl.dstep = 1'b1;
                if (sts.step_done)
                    state_next = S_DONE;
            end
            S_CLAMP:
            begin
                ctl.clamp  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // output register free or being emptied this cycle
                if (!res_valid_reg || res_ready)
                begin
                    ctl.load_res   = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cda_dp.sv =====
// Datapath of the calendar date unit: date registers, month stepping,
// month index divide, day clamp and the result register.
// Depends on cda_pkg; controlled by cda_ctrl.
`default_nettype none

module cda_dp (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [13:0]            cfg_data,
    input  wire cda_pkg::cda_cmd_word_t cmd_word,
    input  wire cda_pkg::cda_ctl_t      ctl,
    output cda_pkg::cda_sts_t           sts,
    output cda_pkg::cda_res_word_t      res_word
);

    logic [13:0]            lsy_reg;
    logic [13:0]            year_reg,  year_next;
    logic [3:0]             month_reg, month_next;
    logic [4:0]             day_reg,   day_next;
    logic [15:0]            n_reg,     n_next;
    logic                   neg_reg,   neg_next;
    logic [16:0]            idx_reg,   idx_next;
    logic                   sat_reg,   sat_next;
    cda_pkg::cda_cmd_word_t item_reg;
    cda_pkg::cda_res_word_t res_reg;

    logic                   leap_cur;
    logic [4:0]             len_cur;
    logic [4:0]             day_clamped;
    logic [4:0]             rem_fwd;
    logic                   fwd_fit;
    logic                   bwd_fit;
    logic                   at_top;
    logic                   at_bottom;
    logic [3:0]             prev_month;
    logic [4:0]             prev_len;
    logic signed [18:0]     idx_s;
    logic signed [16:0]     year_s;
    logic [34:0]            div_prod;
    logic [16:0]            rem12;
    logic [4:0]             dv_sat;
    logic [26:0]            stamp;

    // Current month facts
    assign leap_cur    = cda_pkg::leap_of(year_reg, lsy_reg);
    assign len_cur     = cda_pkg::month_len(month_reg, leap_cur);
    assign day_clamped = (day_reg > len_cur) ? len_cur :
                         (day_reg == 5'd0)   ? 5'd1    : day_reg;

    // Day stepping terms
    assign rem_fwd    = len_cur - day_reg;
    assign fwd_fit    = (n_reg <= {11'd0, rem_fwd});
    assign bwd_fit    = (n_reg < {11'd0, day_reg});
    assign at_top     = (month_reg == 4'd12) && (year_reg == cda_pkg::YEAR_MAX);
    assign at_bottom  = (month_reg == 4'd1) && (year_reg == 14'd0);
    assign prev_month = (month_reg == 4'd1) ? 4'd12 : month_reg - 4'd1;
    // Feb is reached only from March of the same year, so this year's leap applies
    assign prev_len   = cda_pkg::month_len(prev_month, leap_cur);

    // Month index and year sums
    assign idx_s  = $signed({2'b00, year_reg, 3'b000}) + $signed({3'b000, year_reg, 2'b00})
                  + $signed({15'd0, month_reg}) - 19'sd1
                  + $signed({{3{item_reg.amount[15]}}, item_reg.amount});
    assign year_s = $signed({3'b000, year_reg}) + $signed({item_reg.amount[15], item_reg.amount});

    // idx / 12 and idx % 12
    assign div_prod = 35'(idx_reg) * 35'(cda_pkg::RECIP12);
    assign rem12    = idx_reg - 17'({year_reg, 3'b000}) - 17'({year_reg, 2'b00});

    assign dv_sat = (item_reg.day_value > 6'd31) ? 5'd31 : item_reg.day_value[4:0];

    assign stamp = 27'(year_reg) * 27'd10000 + 27'(month_reg) * 27'd100 + 27'(day_reg);

    assign sts.op        = item_reg.op;
    assign sts.step_done = neg_reg ? (bwd_fit || at_bottom) : (fwd_fit || at_top);
    assign res_word      = res_reg;

    // Next values of the date state
    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        n_next     = n_reg;
        neg_next   = neg_reg;
        idx_next   = idx_reg;
        sat_next   = sat_reg;

        if (ctl.exec)
        begin
            case (item_reg.op)
                cda_pkg::OP_SET:
                begin
                    if (item_reg.year_value > cda_pkg::YEAR_MAX)
                    begin
                        year_next = cda_pkg::YEAR_MAX;
                        sat_next  = 1'b1;
                    end
                    else
                    begin
                        year_next = item_reg.year_value;
                        sat_next  = 1'b0;
                    end
                    if (item_reg.month_value == 4'd0)
                        month_next = 4'd1;
                    else if (item_reg.month_value > 4'd12)
                        month_next = 4'd12;
                    else
                        month_next = item_reg.month_value;
                    day_next = dv_sat;
                end
                cda_pkg::OP_DAYS:
                begin
                    // stale day is clamped before stepping
                    day_next = day_clamped;
                    neg_next = item_reg.amount[15];
                    n_next   = item_reg.amount[15] ? 16'(-item_reg.amount)
                                                   : 16'(item_reg.amount);
                    sat_next = 1'b0;
                end
                cda_pkg::OP_MONTHS:
                begin
                    if (idx_s < 19'sd0)
                    begin
                        idx_next = 17'd0;
                        sat_next = 1'b1;
                    end
                    else if (idx_s > $signed({2'b00, cda_pkg::MONTH_IDX_MAX}))
                    begin
                        idx_next = cda_pkg::MONTH_IDX_MAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_s[16:0];
                        sat_next = 1'b0;
                    end
                end
                default:
                begin
                    if (year_s < 17'sd0)
                    begin
                        year_next = 14'd0;
                        sat_next  = 1'b1;
                    end
                    else if (year_s > $signed({3'b000, cda_pkg::YEAR_MAX}))
                    begin
                        year_next = cda_pkg::YEAR_MAX;
                        sat_next  = 1'b1;
                    end
                    else
                    begin
                        year_next = year_s[13:0];
                        sat_next  = 1'b0;
                    end
                end
            endcase
        end

        if (ctl.mdiv)
            year_next = div_prod[cda_pkg::RECIP12_SHIFT +: 14];

        if (ctl.mrem)
            month_next = rem12[3:0] + 4'd1;

        if (ctl.clamp)
            day_next = day_clamped;

        // One month boundary per cycle
        if (ctl.dstep)
        begin
            if (!neg_reg)
            begin
                if (fwd_fit)
                    day_next = day_reg + n_reg[4:0];
                else if (at_top)
                begin
                    day_next = 5'd31;
                    sat_next = 1'b1;
                end
                else
                begin
                    n_next   = n_reg - {11'd0, rem_fwd} - 16'd1;
                    day_next = 5'd1;
                    if (month_reg == 4'd12)
                    begin
                        year_next  = year_reg + 14'd1;
                        month_next = 4'd1;
                    end
                    else
                        month_next = month_reg + 4'd1;
                end
            end
            else
            begin
                if (bwd_fit)
                    day_next = day_reg - n_reg[4:0];
                else if (at_bottom)
                begin
                    day_next = 5'd1;
                    sat_next = 1'b1;
                end
                else
                begin
                    n_next     = n_reg - {11'd0, day_reg};
                    month_next = prev_month;
                    day_next   = prev_len;
                    if (month_reg == 4'd1)
                        year_next = year_reg - 14'd1;
                end
            end
        end
    end

    // Configuration and date state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lsy_reg   <= cda_pkg::LEAP_START_RST;
            year_reg  <= cda_pkg::YEAR_RST;
            month_reg <= cda_pkg::MONTH_RST;
            day_reg   <= cda_pkg::DAY_RST;
        end
        else
        begin
            if (cfg_we)
                lsy_reg <= cfg_data;
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
            item_reg <= cmd_word;
        n_reg   <= n_next;
        neg_reg <= neg_next;
        idx_reg <= idx_next;
        sat_reg <= sat_next;
        if (ctl.load_res)
        begin
            res_reg.year_now     <= year_reg;
            res_reg.month_now    <= month_reg;
            res_reg.day_now      <= day_reg;
            res_reg.month_length <= len_cur;
            res_reg.is_leap      <= leap_cur;
            res_reg.date_stamp   <= stamp;
            res_reg.year_clamped <= sat_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cda_checker.sv =====
// Port-level assertions for the calendar date unit, bound to the top level.
// Depends on cda_pkg and calendar_date_arithmetic_unit.
`default_nettype none

module cda_checker (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   cmd_valid,
    input wire logic                   cmd_ready,
    input wire logic                   res_valid,
    input wire logic                   res_ready,
    input wire cda_pkg::cda_res_word_t res_word
);

    // Stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_word))
        else $error("result word changed while stalled");

    // One command in flight: no acceptance right after another
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while previous one in progress");

    // Result date is a valid calendar date
    a_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_word.month_now >= 4'd1 && res_word.month_now <= 4'd12
                   && res_word.day_now >= 5'd1
                   && res_word.day_now <= res_word.month_length
                   && res_word.month_length >= 5'd28
                   && res_word.year_now <= cda_pkg::YEAR_MAX)
        else $error("result date out of range");

    // Stamp matches the date fields
    a_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_word.date_stamp == 27'(res_word.year_now) * 27'd10000
                                           + 27'(res_word.month_now) * 27'd100
                                           + 27'(res_word.day_now))
        else $error("date stamp mismatch");

endmodule

bind calendar_date_arithmetic_unit cda_checker u_cda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
);

`default_nettype wire
